// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion wrappers shared by the RTL; define NO_ASSERTIONS to drop
// them from a build.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HVL_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HVL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define HVL_ASSERT(lbl, clk, rst_n, prop, msg)
`define HVL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/hvl_pkg.sv =====
// ---------------------------------------------------------------------------
// hvl_pkg
// Types, table layout and fixed-point constants of the HEAVY likelihood core.
// ---------------------------------------------------------------------------
`default_nettype none

package hvl_pkg;

	localparam int SERIES        = 2;
	localparam int DATA_LAGS     = 1;
	localparam int VARIANCE_LAGS = 1;

	// coefficient table layout
	localparam int MAT        = SERIES * SERIES;
	localparam int OFF_A      = SERIES;
	localparam int OFF_B      = OFF_A + DATA_LAGS * MAT;
	localparam int OFF_LB     = OFF_B + VARIANCE_LAGS * MAT;
	localparam int OFF_UB     = OFF_LB + SERIES;
	localparam int OFF_BC     = OFF_UB + SERIES;
	localparam int TABLE_SIZE = OFF_BC + SERIES;
	localparam int TBL_AW     = 4;

	localparam int NDT    = DATA_LAGS * SERIES;
	localparam int NVT    = VARIANCE_LAGS * SERIES;
	localparam int NTERM  = NDT + NVT;
	localparam int TERM_W = $clog2(NTERM);
	localparam int HIST_W = (NDT > 1) ? $clog2(NDT) : 1;
	localparam int SER_W  = 1;

	localparam int ACC_W = 52;
	localparam int DIV_W = 52;

	localparam int LN_2PI_Q16 = 120447;

	localparam logic signed [ACC_W-1:0] MAX31    = 52'sd2147483647;
	localparam logic signed [ACC_W-1:0] MIN32    = -52'sd2147483648;
	localparam logic signed [ACC_W-1:0] MAX47    = 52'sh7FFFFFFFFFFF;
	localparam logic signed [ACC_W-1:0] MIN47    = -52'sh800000000000;
	localparam logic signed [ACC_W-1:0] SUM_INIT = ACC_W'(SERIES * LN_2PI_Q16);
	localparam logic signed [32:0]      LN2_Q30  = 33'sd744261118;
	localparam logic signed [47:0]      TOT_MAX  = {1'b0, {47{1'b1}}};
	localparam logic signed [47:0]      TOT_MIN  = {1'b1, {47{1'b0}}};

	localparam logic [1:0] OP_LOAD    = 2'd0;
	localparam logic [1:0] OP_OBS     = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	typedef struct packed {
		logic [1:0]         operation;
		logic [3:0]         coef_index;
		logic signed [31:0] coef_value;
		logic               component;
		logic [30:0]        obs_value;
	} item_t;

	typedef struct packed {
		logic               out_component;
		logic [30:0]        variance;
		logic signed [47:0] component_loglik;
		logic signed [31:0] step_loglik;
		logic signed [47:0] total_loglik;
		logic               overflow;
		logic               last;
	} result_t;

	function automatic logic signed [47:0] sat48(input logic signed [ACC_W-1:0] v);
		logic signed [47:0] r;
		if (v > MAX47)
			r = TOT_MAX;
		else if (v < MIN47)
			r = TOT_MIN;
		else
			r = v[47:0];
		return r;
	endfunction

	function automatic logic ovf48(input logic signed [ACC_W-1:0] v);
		return (v > MAX47) || (v < MIN47);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/heavy_variance_likelihood_core.sv =====
// ---------------------------------------------------------------------------
// heavy_variance_likelihood_core
// Two-component HEAVY variance recursion with Gaussian quasi-likelihood,
// Q16.16 fixed point, built around one shared multiplier.
// ---------------------------------------------------------------------------
// Load the 16-word coefficient table (intercepts, data-lag and variance-lag
// matrices, lower and upper bounds, backcast) with load transfers, then send
// observations one component per transfer. A table load, a restart or a
// non-final component is taken without a stall. The final component of a
// time step starts a sequencer that holds stall high, and longer while the
// result side stalls: each lag term is one pass through the 33x33 multiplier,
// each logarithm is a one-bit-per-cycle normalize plus sixteen squaring
// passes through the same multiplier, and each division runs through a
// 52-bit restoring divider. Every step runs two divisions and two logarithms
// for the likelihood, plus one of either per row whose variance leaves its
// bounds. Results leave through a single output register, one per component
// in component order, the last marked by last; the next input transfer is
// taken as soon as the final result sits in that register. A negative
// intercept counts as the smallest positive value, backcast stands in for
// lags without history, and overflow is sticky until restart, forcing
// total_loglik to its maximum while set.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module heavy_variance_likelihood_core
	import hvl_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire item_t   item,
	input  wire logic    item_valid,
	output logic         item_stall,
	output result_t      result,
	output logic         result_valid,
	input  wire logic    result_stall
);

	typedef enum logic [26:0] {
		S_IDLE   = 27'h0000001,
		S_ROW    = 27'h0000002,
		S_ROW_W  = 27'h0000004,
		S_T_ADDR = 27'h0000008,
		S_T_COEF = 27'h0000010,
		S_T_OPND = 27'h0000020,
		S_T_PROD = 27'h0000040,
		S_T_ACC  = 27'h0000080,
		S_LB     = 27'h0000100,
		S_LB_W   = 27'h0000200,
		S_UB_W   = 27'h0000400,
		S_LOWQ   = 27'h0000800,
		S_HIGHQ  = 27'h0001000,
		S_FIX    = 27'h0002000,
		S_LIK    = 27'h0004000,
		S_LDIV   = 27'h0008000,
		S_LACC   = 27'h0010000,
		S_STEP   = 27'h0020000,
		S_EMIT   = 27'h0040000,
		S_DIV    = 27'h0080000,
		S_NORM   = 27'h0100000,
		S_SQ     = 27'h0200000,
		S_SQ_W   = 27'h0400000,
		S_SQ_R   = 27'h0800000,
		S_LN     = 27'h1000000,
		S_LN_W   = 27'h2000000,
		S_LN_R   = 27'h4000000
	} state_t;

	state_t state_q, ret_q;

	// coefficient table
	logic signed [31:0] tbl_q [TABLE_SIZE];
	logic signed [31:0] rdata_q;
	logic [TBL_AW-1:0]  raddr;
	logic               tbl_we;

	// series state
	logic signed [31:0] dhist_q [NDT];
	logic signed [31:0] vhist_q [NVT];
	logic [30:0]        obs_q [SERIES];
	logic [30:0]        hv_q [SERIES];
	logic signed [47:0] cs_q [SERIES];
	logic signed [47:0] total_q;
	logic signed [31:0] step_q;
	logic               flag_q;
	logic [2:0]         steps_q;

	// sequencer working registers
	logic signed [ACC_W-1:0] acc_q, sum_q;
	logic signed [31:0]      lb_q, ub_q, lg_q, lres_q;
	logic                    neg_q;
	logic [SER_W-1:0]        l_q, e_q;
	logic [TERM_W-1:0]       t_q;

	// shared multiplier
	logic signed [32:0] mul_a_q, mul_b_q;
	logic signed [65:0] prod_q;

	// logarithm and divider
	logic [ACC_W-1:0] lx_q;
	logic [5:0]       ln_n_q;
	logic [30:0]      sq_q;
	logic [15:0]      frac_q;
	logic [3:0]       bit_q;
	logic [DIV_W-1:0] dq_q, drem_q, dden_q;
	logic [5:0]       dcnt_q;

	result_t res_q;
	logic    res_valid_q;

	logic accept;
	logic emit_load;

	// term decode
	logic              is_var;
	logic [TERM_W-1:0] tt;
	logic [SER_W-1:0]  k_idx;
	int                j_lag;
	logic [TBL_AW-1:0] coef_addr;
	logic [HIST_W-1:0] hist_idx;
	logic signed [31:0] opnd;

	// datapath helpers
	logic signed [65:0]      prod_sh16, ln_rnd;
	logic [31:0]             sq_y;
	logic signed [6:0]       nm16;
	logic [DIV_W:0]          rem_sh, rem_sub;
	logic                    div_ge;
	logic signed [ACC_W-1:0] lb_x, ubr_x, ubq_x, lb_num, low_den;
	logic signed [ACC_W-1:0] tsum, cs_new, step_full, tot_new;
	logic                    step_hi, step_lo;

	assign accept     = item_valid && (state_q == S_IDLE);
	assign item_stall = (state_q != S_IDLE);
	assign tbl_we     = accept && (item.operation == OP_LOAD)
		&& (int'(item.coef_index) < TABLE_SIZE);

	// load the output register when it is empty or its result transfers
	assign emit_load  = (state_q == S_EMIT) && (!res_valid_q || !result_stall);

	assign result       = res_q;
	assign result_valid = res_valid_q;

	always_comb begin
		is_var    = (t_q >= TERM_W'(NDT));
		tt        = is_var ? (t_q - TERM_W'(NDT)) : t_q;
		k_idx     = SER_W'(tt % SERIES);
		j_lag     = int'(tt) / SERIES;
		coef_addr = TBL_AW'((is_var ? OFF_B : OFF_A) + j_lag * MAT
			+ int'(l_q) * SERIES + int'(k_idx));
		hist_idx  = HIST_W'(tt);
		if (int'(steps_q) > j_lag)
			opnd = is_var ? vhist_q[hist_idx] : dhist_q[hist_idx];
		else
			opnd = rdata_q;
	end

	always_comb begin
		raddr = '0;
		case (state_q)
			S_ROW:    raddr = TBL_AW'(int'(l_q));
			S_T_ADDR: raddr = coef_addr;
			S_T_COEF: raddr = TBL_AW'(OFF_BC + int'(k_idx));
			S_LB:     raddr = TBL_AW'(OFF_LB + int'(l_q));
			S_LB_W:   raddr = TBL_AW'(OFF_UB + int'(l_q));
			default:  raddr = '0;
		endcase
	end

	always_comb begin
		prod_sh16 = prod_q >>> 16;
		ln_rnd    = (prod_q + 66'sd536870912) >>> 30;
		sq_y      = prod_q[61:30];
		nm16      = $signed(7'(ln_n_q) - 7'd16);
		rem_sh    = {drem_q, dq_q[DIV_W-1]};
		rem_sub   = rem_sh - {1'b0, dden_q};
		div_ge    = (rem_sh >= {1'b0, dden_q});
		lb_x      = {{(ACC_W-32){lb_q[31]}}, lb_q};
		ubr_x     = {{(ACC_W-32){rdata_q[31]}}, rdata_q};
		ubq_x     = {{(ACC_W-32){ub_q[31]}}, ub_q};
		lb_num    = lb_x <<< 16;
		low_den   = 52'sd65536 - acc_q + lb_x;
		tsum      = {{(ACC_W-32){lg_q[31]}}, lg_q} + $signed(dq_q);
		cs_new    = {{(ACC_W-48){cs_q[l_q][47]}}, cs_q[l_q]} - (tsum >>> 1);
		step_full = sum_q >>> 1;
		tot_new   = {{(ACC_W-48){total_q[47]}}, total_q} + step_full;
		step_hi   = (step_full > MAX31);
		step_lo   = (step_full < MIN32);
	end

	// table storage, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (tbl_we)
			tbl_q[item.coef_index] <= item.coef_value;
		rdata_q <= tbl_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			for (int i = 0; i < NDT; i++)
				dhist_q[i] <= '0;
			for (int i = 0; i < NVT; i++)
				vhist_q[i] <= '0;
			for (int i = 0; i < SERIES; i++) begin
				obs_q[i] <= '0;
				hv_q[i]  <= '0;
				cs_q[i]  <= '0;
			end
			total_q     <= '0;
			step_q      <= '0;
			flag_q      <= 1'b0;
			steps_q     <= '0;
			acc_q       <= '0;
			sum_q       <= '0;
			lb_q        <= '0;
			ub_q        <= '0;
			lg_q        <= '0;
			lres_q      <= '0;
			neg_q       <= 1'b0;
			l_q         <= '0;
			e_q         <= '0;
			t_q         <= '0;
			mul_a_q     <= '0;
			mul_b_q     <= '0;
			prod_q      <= '0;
			lx_q        <= '0;
			ln_n_q      <= '0;
			sq_q        <= '0;
			frac_q      <= '0;
			bit_q       <= '0;
			dq_q        <= '0;
			drem_q      <= '0;
			dden_q      <= '0;
			dcnt_q      <= '0;
			res_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			prod_q <= mul_a_q * mul_b_q;
			// hold a fresh result, drop the held one once it transfers
			if (emit_load)
				res_valid_q <= 1'b1;
			else if (!result_stall)
				res_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (item.operation)
							OP_RESTART: begin
								for (int i = 0; i < NDT; i++)
									dhist_q[i] <= '0;
								for (int i = 0; i < NVT; i++)
									vhist_q[i] <= '0;
								for (int i = 0; i < SERIES; i++) begin
									obs_q[i] <= '0;
									cs_q[i]  <= '0;
								end
								total_q <= '0;
								flag_q  <= 1'b0;
								steps_q <= '0;
							end
							OP_OBS: begin
								if (int'(item.component) < SERIES) begin
									obs_q[item.component] <= item.obs_value;
									if (item.component == SER_W'(SERIES - 1)) begin
										l_q     <= '0;
										state_q <= S_ROW;
									end
								end
							end
							default: ;
						endcase
					end
				end
				S_ROW: begin
					t_q     <= '0;
					state_q <= S_ROW_W;
				end
				S_ROW_W: begin
					// negative intercept counts as the smallest positive value
					acc_q   <= rdata_q[31] ? 52'sd1 : {{(ACC_W-32){1'b0}}, rdata_q};
					state_q <= S_T_ADDR;
				end
				S_T_ADDR: state_q <= S_T_COEF;
				S_T_COEF: begin
					mul_a_q <= {rdata_q[31], rdata_q};
					state_q <= S_T_OPND;
				end
				S_T_OPND: begin
					mul_b_q <= {opnd[31], opnd};
					state_q <= S_T_PROD;
				end
				S_T_PROD: state_q <= S_T_ACC;
				S_T_ACC: begin
					acc_q <= acc_q + prod_sh16[ACC_W-1:0];
					if (t_q == TERM_W'(NTERM - 1)) begin
						state_q <= S_LB;
					end else begin
						t_q     <= t_q + 1'b1;
						state_q <= S_T_ADDR;
					end
				end
				S_LB:   state_q <= S_LB_W;
				S_LB_W: begin
					lb_q    <= rdata_q;
					state_q <= S_UB_W;
				end
				S_UB_W: begin
					ub_q <= rdata_q;
					if (acc_q < lb_x) begin
						// soft clamp below: lb*65536 / (65536 - h + lb)
						dq_q    <= lb_q[31] ? $unsigned(-lb_num) : $unsigned(lb_num);
						drem_q  <= '0;
						dden_q  <= $unsigned(low_den);
						dcnt_q  <= 6'(DIV_W - 1);
						neg_q   <= lb_q[31];
						ret_q   <= S_LOWQ;
						state_q <= S_DIV;
					end else if (acc_q > ubr_x) begin
						// soft clamp above: ub + ln(h - ub)
						lx_q    <= $unsigned(acc_q - ubr_x);
						ln_n_q  <= 6'(ACC_W - 1);
						ret_q   <= S_HIGHQ;
						state_q <= S_NORM;
					end else begin
						state_q <= S_FIX;
					end
				end
				S_LOWQ: begin
					acc_q   <= neg_q ? -$signed(dq_q) : $signed(dq_q);
					state_q <= S_FIX;
				end
				S_HIGHQ: begin
					acc_q   <= ubq_x + {{(ACC_W-32){lres_q[31]}}, lres_q};
					state_q <= S_FIX;
				end
				S_FIX: begin
					if (acc_q <= 0) begin
						hv_q[l_q] <= 31'd1;
						flag_q    <= 1'b1;
					end else if (acc_q > MAX31) begin
						hv_q[l_q] <= '1;
						flag_q    <= 1'b1;
					end else begin
						hv_q[l_q] <= acc_q[30:0];
					end
					if (l_q == SER_W'(SERIES - 1)) begin
						l_q     <= '0;
						sum_q   <= SUM_INIT;
						state_q <= S_LIK;
					end else begin
						l_q     <= l_q + 1'b1;
						state_q <= S_ROW;
					end
				end
				S_LIK: begin
					lx_q    <= {{(ACC_W-31){1'b0}}, hv_q[l_q]};
					ln_n_q  <= 6'(ACC_W - 1);
					ret_q   <= S_LDIV;
					state_q <= S_NORM;
				end
				S_LDIV: begin
					lg_q    <= lres_q;
					dq_q    <= {{(DIV_W-47){1'b0}}, obs_q[l_q], 16'd0};
					drem_q  <= '0;
					dden_q  <= {{(DIV_W-31){1'b0}}, hv_q[l_q]};
					dcnt_q  <= 6'(DIV_W - 1);
					ret_q   <= S_LACC;
					state_q <= S_DIV;
				end
				S_LACC: begin
					sum_q     <= sum_q + tsum;
					cs_q[l_q] <= sat48(cs_new);
					if (ovf48(cs_new))
						flag_q <= 1'b1;
					if (l_q == SER_W'(SERIES - 1)) begin
						state_q <= S_STEP;
					end else begin
						l_q     <= l_q + 1'b1;
						state_q <= S_LIK;
					end
				end
				S_STEP: begin
					total_q <= sat48(tot_new);
					if (step_hi)
						step_q <= 32'sh7FFFFFFF;
					else if (step_lo)
						step_q <= 32'sh80000000;
					else
						step_q <= step_full[31:0];
					flag_q <= flag_q | ovf48(tot_new) | step_hi | step_lo;
					// advance the lag lines
					for (int d = NDT - 1; d >= SERIES; d--)
						dhist_q[d] <= dhist_q[d - SERIES];
					for (int d = NVT - 1; d >= SERIES; d--)
						vhist_q[d] <= vhist_q[d - SERIES];
					for (int k = 0; k < SERIES; k++) begin
						dhist_q[k] <= {1'b0, obs_q[k]};
						vhist_q[k] <= {1'b0, hv_q[k]};
					end
					if (steps_q != 3'd7)
						steps_q <= steps_q + 3'd1;
					e_q     <= '0;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_load) begin
						res_q.out_component    <= e_q;
						res_q.variance         <= hv_q[e_q];
						res_q.component_loglik <= cs_q[e_q];
						res_q.step_loglik      <= step_q;
						res_q.total_loglik     <= flag_q ? TOT_MAX : total_q;
						res_q.overflow         <= flag_q;
						res_q.last             <= (e_q == SER_W'(SERIES - 1));
						if (e_q == SER_W'(SERIES - 1))
							state_q <= S_IDLE;
						else
							e_q <= e_q + 1'b1;
					end
				end
				S_DIV: begin
					dq_q   <= {dq_q[DIV_W-2:0], div_ge};
					drem_q <= div_ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
					if (dcnt_q == '0)
						state_q <= ret_q;
					else
						dcnt_q <= dcnt_q - 6'd1;
				end
				S_NORM: begin
					if (lx_q == '0) begin
						lres_q  <= '0;
						state_q <= ret_q;
					end else if (lx_q[ACC_W-1]) begin
						sq_q    <= lx_q[ACC_W-1 -: 31];
						frac_q  <= '0;
						bit_q   <= 4'd15;
						state_q <= S_SQ;
					end else begin
						lx_q   <= lx_q << 1;
						ln_n_q <= ln_n_q - 6'd1;
					end
				end
				S_SQ: begin
					mul_a_q <= {2'b00, sq_q};
					mul_b_q <= {2'b00, sq_q};
					state_q <= S_SQ_W;
				end
				S_SQ_W: state_q <= S_SQ_R;
				S_SQ_R: begin
					if (sq_y[31]) begin
						sq_q          <= sq_y[31:1];
						frac_q[bit_q] <= 1'b1;
					end else begin
						sq_q <= sq_y[30:0];
					end
					if (bit_q == '0) begin
						state_q <= S_LN;
					end else begin
						bit_q   <= bit_q - 4'd1;
						state_q <= S_SQ;
					end
				end
				S_LN: begin
					mul_a_q <= {{10{nm16[6]}}, nm16, frac_q};
					mul_b_q <= LN2_Q30;
					state_q <= S_LN_W;
				end
				S_LN_W: state_q <= S_LN_R;
				S_LN_R: begin
					lres_q  <= ln_rnd[31:0];
					state_q <= ret_q;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`HVL_ASSERT_NEXT(a_final_obs_starts, clk, arst_n, item_valid && !item_stall && (item.operation == OP_OBS) && (item.component == SER_W'(SERIES - 1)), state_q == S_ROW, "final component did not start a step")
	`HVL_ASSERT(a_variance_positive, clk, arst_n, result_valid |-> (result.variance != '0), "variance result is zero")
	`HVL_ASSERT(a_overflow_total, clk, arst_n, (result_valid && result.overflow) |-> (result.total_loglik == TOT_MAX), "total not saturated under overflow")
	`HVL_ASSERT(a_norm_nonzero, clk, arst_n, (state_q == S_SQ) |-> (sq_q[30] == 1'b1), "log mantissa not normalized")

endmodule

`default_nettype wire

// ===== bench/heavy_variance_likelihood_checker.sv =====
// ---------------------------------------------------------------------------
// heavy_variance_likelihood_checker
// Watches both channels of the HEAVY likelihood core, predicts each result
// from the accepted transfers and compares the results field by field.
// ---------------------------------------------------------------------------
`default_nettype none

module heavy_variance_likelihood_checker
	import hvl_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire item_t   item,
	input  wire logic    item_valid,
	input  wire logic    item_stall,
	input  wire result_t result,
	input  wire logic    result_valid,
	input  wire logic    result_stall,
	output int           fail_count,
	output int           results_due
);

	localparam longint SAT_HI = 64'sh7FFFFFFFFFFF;
	localparam longint SAT_LO = -64'sh800000000000;

	logic signed [31:0] coefs [TABLE_SIZE];
	longint             obs_prev [SERIES];
	longint             var_prev [SERIES];
	longint             obs_now [SERIES];
	int                 steps_done;
	longint             comp_ll [SERIES];
	longint             total_ll;
	bit                 ovf_seen;
	result_t            result_queue [$];

	initial begin
		fail_count  = 0;
		results_due = 0;
		steps_done  = 0;
		total_ll    = 0;
		ovf_seen    = 0;
		for (int i = 0; i < SERIES; i++) begin
			obs_prev[i] = 0;
			var_prev[i] = 0;
			obs_now[i]  = 0;
			comp_ll[i]  = 0;
		end
	end

	task automatic report(input string field, input longint got, input longint want);
		$display("mismatch %s: got %0d want %0d at %0t", field, got, want, $realtime);
		fail_count++;
	endtask

	// natural log of a positive Q16.16 value, 16 squaring steps on a Q30 mantissa
	function automatic longint nat_log(input longint unsigned x);
		int              n;
		int              i;
		longint unsigned y;
		longint          frac;
		longint          l2;
		if (x == 0)
			return 0;
		n = 63;
		while (x[n] == 1'b0)
			n--;
		y = (n >= 30) ? (x >> (n - 30)) : (x << (30 - n));
		frac = 0;
		for (i = 15; i >= 0; i--) begin
			y = (y * y) >> 30;
			if (y >= (64'd2 << 30)) begin
				y = y >> 1;
				frac = frac | (64'sd1 << i);
			end
		end
		l2 = (longint'(n) - 16) * 65536 + frac;
		return (l2 * longint'(LN2_Q30) + (64'sd1 << 29)) >>> 30;
	endfunction

	function automatic longint clip48(input longint v);
		if (v > SAT_HI) begin
			ovf_seen = 1;
			return SAT_HI;
		end
		if (v < SAT_LO) begin
			ovf_seen = 1;
			return SAT_LO;
		end
		return v;
	endfunction

	// advance the variance recursion on one accepted transfer
	task automatic predict_step(input item_t it);
		longint  hv [SERIES];
		longint  acc, lb, ub, v, lg, ratio, sum_all, step, tot;
		result_t r;
		if (it.operation == OP_LOAD) begin
			if (int'(it.coef_index) < TABLE_SIZE)
				coefs[it.coef_index] = it.coef_value;
			return;
		end
		if (it.operation == OP_RESTART) begin
			for (int i = 0; i < SERIES; i++) begin
				obs_prev[i] = 0;
				var_prev[i] = 0;
				obs_now[i]  = 0;
				comp_ll[i]  = 0;
			end
			steps_done = 0;
			total_ll   = 0;
			ovf_seen   = 0;
			return;
		end
		if (it.operation != OP_OBS || int'(it.component) >= SERIES)
			return;
		obs_now[it.component] = longint'(it.obs_value);
		if (int'(it.component) != SERIES - 1)
			return;

		for (int l = 0; l < SERIES; l++) begin
			acc = longint'(coefs[l]);
			lb  = longint'(coefs[OFF_LB + l]);
			ub  = longint'(coefs[OFF_UB + l]);
			// a negative intercept counts as the smallest positive value
			if (acc < 0)
				acc = 1;
			for (int k = 0; k < SERIES; k++) begin
				v = (steps_done > 0) ? obs_prev[k] : longint'(coefs[OFF_BC + k]);
				acc += (longint'(coefs[OFF_A + l * SERIES + k]) * v) >>> 16;
			end
			for (int k = 0; k < SERIES; k++) begin
				v = (steps_done > 0) ? var_prev[k] : longint'(coefs[OFF_BC + k]);
				acc += (longint'(coefs[OFF_B + l * SERIES + k]) * v) >>> 16;
			end
			if (acc < lb)
				acc = (lb * 65536) / (65536 - acc + lb);
			else if (acc > ub)
				acc = ub + nat_log(acc - ub);
			if (acc <= 0) begin
				acc = 1;
				ovf_seen = 1;
			end
			if (acc > 64'sh7FFFFFFF) begin
				acc = 64'sh7FFFFFFF;
				ovf_seen = 1;
			end
			hv[l] = acc;
		end

		sum_all = longint'(SERIES) * LN_2PI_Q16;
		for (int l = 0; l < SERIES; l++) begin
			lg = nat_log(hv[l]);
			ratio = (obs_now[l] << 16) / hv[l];
			sum_all += lg + ratio;
			comp_ll[l] = clip48(comp_ll[l] - ((lg + ratio) >>> 1));
		end
		step = sum_all >>> 1;
		total_ll = clip48(total_ll + step);
		if (step > 64'sh7FFFFFFF) begin
			step = 64'sh7FFFFFFF;
			ovf_seen = 1;
		end
		if (step < -64'sh80000000) begin
			step = -64'sh80000000;
			ovf_seen = 1;
		end

		for (int l = 0; l < SERIES; l++) begin
			obs_prev[l] = obs_now[l];
			var_prev[l] = hv[l];
		end
		if (steps_done < 7)
			steps_done++;

		tot = ovf_seen ? SAT_HI : total_ll;
		for (int l = 0; l < SERIES; l++) begin
			r.out_component    = l[0];
			r.variance         = hv[l][30:0];
			r.component_loglik = comp_ll[l][47:0];
			r.step_loglik      = step[31:0];
			r.total_loglik     = tot[47:0];
			r.overflow         = ovf_seen;
			r.last             = (l == SERIES - 1);
			result_queue.push_back(r);
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (result_queue.size() == 0) begin
				report("unexpected result", 1, 0);
			end else begin
				want = result_queue.pop_front();
				if (result.out_component != want.out_component)
					report("out_component", result.out_component, want.out_component);
				if (result.variance != want.variance)
					report("variance", result.variance, want.variance);
				if (result.component_loglik != want.component_loglik)
					report("component_loglik", result.component_loglik,
						want.component_loglik);
				if (result.step_loglik != want.step_loglik)
					report("step_loglik", result.step_loglik, want.step_loglik);
				if (result.total_loglik != want.total_loglik)
					report("total_loglik", result.total_loglik, want.total_loglik);
				if (result.overflow != want.overflow)
					report("overflow", result.overflow, want.overflow);
				if (result.last != want.last)
					report("last", result.last, want.last);
			end
		end
		if (arst_n && item_valid && !item_stall)
			predict_step(item);
		results_due = result_queue.size();
	end

endmodule

`default_nettype wire

// ===== bench/heavy_variance_likelihood_core_tb.sv =====
// ---------------------------------------------------------------------------
// heavy_variance_likelihood_core_tb
// Drives table loads, observations and restarts into the likelihood core,
// with random idle bursts on both channels; the checker beside the core
// predicts and compares every result.
// ---------------------------------------------------------------------------
`default_nettype none

module heavy_variance_likelihood_core_tb;
	import hvl_pkg::*;

	localparam int  ITEM_TARGET = 330;
	localparam int  QUIET_TAIL  = 40;
	localparam longint CYCLE_LIMIT = 2000000;
	localparam logic [1:0] OP_UNKNOWN = 2'd3;

	logic    clk;
	logic    arst_n;
	item_t   item;
	logic    item_valid;
	logic    item_stall;
	result_t result;
	logic    result_valid;
	logic    result_stall;
	int      fail_count;
	int      results_due;
	bit      quiet;
	int      sent;
	longint  cycles;

	heavy_variance_likelihood_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

	heavy_variance_likelihood_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.fail_count   (fail_count),
		.results_due  (results_due)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// hard stop in case the core hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver side: stall in random bursts, none once the tail begins
	initial begin
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	// present one transfer and hold it until accepted; valid stays high
	// between back-to-back transfers and in this task only drops for an idle burst
	task automatic send(input item_t it);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		sent++;
		if (sent >= ITEM_TARGET - QUIET_TAIL)
			quiet = 1;
	endtask

	task automatic load_word(input int idx, input logic signed [31:0] val);
		item_t it;
		it = '{operation: OP_LOAD, coef_index: idx[3:0], coef_value: val,
			component: 1'($urandom_range(0, 1)), obs_value: 31'($urandom)};
		send(it);
	endtask

	task automatic observe(input int comp, input logic [30:0] val);
		item_t it;
		it = '{operation: OP_OBS, coef_index: 4'($urandom), coef_value: $urandom,
			component: comp[0], obs_value: val};
		send(it);
	endtask

	task automatic control(input logic [1:0] opc);
		item_t it;
		it = '{operation: opc, coef_index: 4'($urandom), coef_value: $urandom,
			component: 1'($urandom_range(0, 1)), obs_value: 31'($urandom)};
		send(it);
	endtask

	// a plausible coefficient for each table slot
	function automatic logic signed [31:0] sane_coef(input int idx);
		if (idx < OFF_A)
			return $urandom_range(0, 131072) - (($urandom_range(0, 7) == 0) ? 200000 : 0);
		if (idx < OFF_LB)
			return $urandom_range(0, 40000);
		if (idx < OFF_UB)
			return $urandom_range(0, 20000);
		if (idx < OFF_BC)
			return $urandom_range(200000, 4000000);
		return $urandom_range(0, 200000);
	endfunction

	function automatic logic [30:0] rand_obs();
		if ($urandom_range(0, 9) == 0)
			return 31'($urandom);
		return 31'($urandom_range(0, 300000));
	endfunction

	task automatic step_pair();
		observe(0, rand_obs());
		observe(1, rand_obs());
	endtask

	initial begin
		int pick;
		arst_n     = 1'b0;
		item       = '0;
		item_valid = 1'b0;
		quiet      = 0;
		sent       = 0;
		cycles     = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes of the word first, then a full sane table
		load_word(0, 32'sh7FFFFFFF);
		load_word(1, -32'sh80000000);
		for (int i = 0; i < TABLE_SIZE; i++)
			load_word(i, sane_coef(i));
		observe(0, '0);
		observe(1, '1);
		control(OP_UNKNOWN);        // unknown operation, dropped
		// negative intercept
		load_word(0, -32'sh80000000);
		step_pair();
		// lower bound far above the recursion
		load_word(OFF_LB, 32'sh7FFFFFFF);
		step_pair();
		load_word(OFF_LB, 0);
		// upper bound below the recursion, log soft clamp
		load_word(OFF_UB + 1, 16);
		step_pair();
		// non-positive variance: negative lags against a negative lower bound
		load_word(OFF_A, -32'sh80000000);
		load_word(OFF_LB, -32'sh10000);
		observe(0, '1);
		observe(1, '1);
		// oversized variance with a top upper bound
		load_word(OFF_A + 3, 32'sh7FFFFFFF);
		load_word(OFF_UB + 1, 32'sh7FFFFFFF);
		step_pair();
		control(OP_RESTART);
		for (int i = 0; i < TABLE_SIZE; i++)
			load_word(i, sane_coef(i));

		// pause the sender until every expected result has come
		item_valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0)
			@(posedge clk);

		// random: mostly well-formed time steps
		while (sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 62)
				step_pair();
			else if (pick < 68)
				observe($urandom_range(0, 1), rand_obs());
			else if (pick < 82)
				load_word($urandom_range(0, TABLE_SIZE - 1),
					sane_coef($urandom_range(0, TABLE_SIZE - 1)));
			else if (pick < 87)
				load_word($urandom_range(0, TABLE_SIZE - 1), $urandom);
			else if (pick < 92)
				control(OP_RESTART);
			else if (pick < 94)
				control(OP_UNKNOWN);
			else begin
				// fresh sane table; in the first half of the run, drain everything before going on
				for (int i = 0; i < TABLE_SIZE; i++)
					load_word(i, sane_coef(i));
				if (sent < ITEM_TARGET / 2) begin
					item_valid <= 1'b0;
					while (results_due != 0)
						@(posedge clk);
				end
			end
		end
		item_valid <= 1'b0;
		@(posedge clk);

		while (results_due != 0)
			@(posedge clk);
		repeat (600) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire
